FILE: rtl/core/tga_rle_pixel_decoder_assert.svh
// Assertion macros for the TGA pixel decoder, empty when synthesized.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TGA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TGA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TGA_ASSERT(label, prop, msg)
`define TGA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/tga_pkg.sv
// Shared types and constants of the TGA pixel decoder.
package tga_pkg;
   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] BPP_24   = 8'd24;
   localparam logic [7:0] BPP_32   = 8'd32;

   localparam logic [1:0] CSR_IMAGE_TYPE   = 2'd0;
   localparam logic [1:0] CSR_BITS_PER_PIX = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd3;

   localparam int QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [7:0]  image_type;
      logic [7:0]  bits_per_pixel;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

   // one unit of work for the back end: a pixel and its repeat count
   typedef struct packed {
      logic        fmt_err;
      logic [7:0]  count;
      logic [23:0] pixel;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;
endpackage

FILE: rtl/core/tga_if.sv
// Valid/ready channel interfaces for the byte input and the pixel output.
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_a;
   logic [23:0] pixel_b;
   logic [23:0] pixel_c;
   logic [23:0] pixel_d;
   logic [2:0]  pixels_valid;
   logic        run_last;
   logic        image_done;
   logic        overflow;
   logic        format_error;
   modport source (output valid, output pixel_a, output pixel_b, output pixel_c,
                   output pixel_d, output pixels_valid, output run_last,
                   output image_done, output overflow, output format_error,
                   input ready);
   modport sink (input valid, input pixel_a, input pixel_b, input pixel_c,
                 input pixel_d, input pixels_valid, input run_last,
                 input image_done, input overflow, input format_error,
                 output ready);
endinterface

FILE: rtl/core/tga_rle_pixel_decoder.sv
// TGA truecolor pixel decoder top level: config registers, front end, job queue, expander.
// A byte is taken every cycle while the job queue has room; a finished pixel passes through
// the job queue, the expander's job registers and its registered outputs to reach the pins.
// The expander loads each pixel job while idle and emits it up to four pixels a beat, with
// one beat even when no pixel is kept; input stalls once the queue fills.
// Synchronous active-high reset clears stream state and loads type 2, 24 bpp, 0 x 0.
`include "tga_rle_pixel_decoder_assert.svh"
module tga_rle_pixel_decoder #(
   parameter int QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tga_req_if.sink     req_chan,
   tga_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import tga_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   qstat_type qstat;
   job_type   front_job;
   job_type   head_job;
   logic      front_push;
   logic      back_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_TYPE:   cfg_in.image_type = csr_wr_data[7:0];
            CSR_BITS_PER_PIX: cfg_in.bits_per_pixel = csr_wr_data[7:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width = csr_wr_data;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_type <= TYPE_RAW;
         cfg_ff.bits_per_pixel <= BPP_24;
         cfg_ff.image_width <= 16'd0;
         cfg_ff.image_height <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tga_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (front_push),
      .job      (front_job)
   );

   tga_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .job_in  (front_job),
      .pop     (back_pop),
      .job_out (head_job),
      .qstat   (qstat)
   );

   tga_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (head_job),
      .qstat    (qstat),
      .pop      (back_pop),
      .rsp_chan (rsp_chan)
   );

   `TGA_ASSERT_ALWAYS(a_push_room, front_push |-> !qstat.full, "job pushed into full queue")
   `TGA_ASSERT(a_pop_nonempty, back_pop |-> !qstat.empty, "job popped from empty queue")
   `TGA_ASSERT(a_done_last, rsp_chan.valid && rsp_chan.image_done |-> rsp_chan.run_last && rsp_chan.pixels_valid != 3'd0, "image done without final pixels")
   `TGA_ASSERT(a_fmt_clean, rsp_chan.valid && rsp_chan.format_error |-> rsp_chan.pixels_valid == 3'd0 && !rsp_chan.overflow && rsp_chan.run_last, "format error beat carries data")
endmodule

FILE: rtl/core/tga_front.sv
// Byte front end: packet parsing, pixel assembly and job generation.
module tga_front (
   input  logic               clock,
   input  logic               reset,
   input  tga_pkg::cfg_type   cfg,
   tga_req_if.sink            req_chan,
   input  tga_pkg::qstat_type qstat,
   output logic               push,
   output tga_pkg::job_type   job
);
   import tga_pkg::*;

   logic [7:0]  rem_ff, rem_in;
   logic        rep_ff, rep_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] asm_ff, asm_in;

   logic        accept;
   logic        fmt_bad;
   logic [1:0]  last_idx;
   logic [23:0] asm_take;
   logic        take_done;
   logic [1:0]  bip_take;
   logic [7:0]  data;

   assign req_chan.ready = !qstat.full;
   assign accept = req_chan.valid && req_chan.ready;
   assign data = req_chan.data_byte;

   assign fmt_bad = !(cfg.bits_per_pixel == BPP_24 || cfg.bits_per_pixel == BPP_32) ||
                    !(cfg.image_type == TYPE_RAW || cfg.image_type == TYPE_RLE);
   assign last_idx = (cfg.bits_per_pixel == BPP_32) ? 2'd3 : 2'd2;

   // bytes arrive B, G, R (, A); alpha is dropped
   always_comb begin
      asm_take = asm_ff;
      case (bip_ff)
         2'd0: asm_take[7:0]   = data;
         2'd1: asm_take[15:8]  = data;
         2'd2: asm_take[23:16] = data;
         default: asm_take = asm_ff;
      endcase
   end

   assign take_done = bip_ff >= last_idx;
   assign bip_take  = take_done ? 2'd0 : bip_ff + 2'd1;

   always_comb begin
      rem_in = rem_ff;
      rep_in = rep_ff;
      bip_in = bip_ff;
      asm_in = asm_ff;
      push = 1'b0;
      job.fmt_err = 1'b0;
      job.count = 8'd1;
      job.pixel = asm_take;
      if (accept) begin
         if (fmt_bad) begin
            push = 1'b1;
            job.fmt_err = 1'b1;
         end else if (cfg.image_type == TYPE_RAW) begin
            asm_in = asm_take;
            bip_in = bip_take;
            push = take_done;
         end else if (rem_ff == 8'd0) begin
            // packet header
            rem_in = {1'b0, data[6:0]} + 8'd1;
            rep_in = data[7];
            bip_in = 2'd0;
         end else begin
            asm_in = asm_take;
            bip_in = bip_take;
            if (take_done) begin
               push = 1'b1;
               if (rep_ff) begin
                  job.count = rem_ff;
                  rem_in = 8'd0;
               end else begin
                  rem_in = rem_ff - 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 8'd0;
         rep_ff <= 1'b0;
         bip_ff <= 2'd0;
         asm_ff <= 24'd0;
      end else begin
         rem_ff <= rem_in;
         rep_ff <= rep_in;
         bip_ff <= bip_in;
         asm_ff <= asm_in;
      end
   end
endmodule

FILE: rtl/core/tga_queue.sv
// Short job queue between the front end and the run expander.
module tga_queue #(
   parameter int DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tga_pkg::job_type   job_in,
   input  logic               pop,
   output tga_pkg::job_type   job_out,
   output tga_pkg::qstat_type qstat
);
   import tga_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign qstat.full  = cnt_ff == CNT_W'(DEPTH);
   assign qstat.empty = cnt_ff == '0;
   assign job_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

FILE: rtl/core/tga_back.sv
// Run expander: clips jobs to the image size and emits up to four pixels a beat.
module tga_back (
   input  logic               clock,
   input  logic               reset,
   input  tga_pkg::cfg_type   cfg,
   input  tga_pkg::job_type   job,
   input  tga_pkg::qstat_type qstat,
   output logic               pop,
   tga_rsp_if.source          rsp_chan
);
   import tga_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic        state_ff, state_in;
   logic [31:0] total_ff;
   logic [31:0] written_ff, written_in;
   logic        finished_ff, finished_in;
   logic [7:0]  left_ff, left_in;
   logic [23:0] pix_ff, pix_in;
   logic        drop_ff, drop_in;
   logic        fmt_ff, fmt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_pix_ff, rsp_pix_in;
   logic [2:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;
   logic        rsp_ovf_ff, rsp_ovf_in;
   logic        rsp_fmt_ff, rsp_fmt_in;

   logic [31:0] total_prod;
   logic [31:0] room;
   logic [7:0]  valid_n;
   logic [2:0]  k;
   logic [7:0]  left_next;
   logic [31:0] sum;
   logic        out_free;

   assign total_prod = 32'(cfg.image_width) * 32'(cfg.image_height);
   assign room = (!finished_ff && written_ff < total_ff) ? total_ff - written_ff : 32'd0;
   assign valid_n = (room > {24'd0, job.count}) ? job.count : room[7:0];
   assign k = (left_ff > 8'd4) ? 3'd4 : left_ff[2:0];
   assign left_next = left_ff - {5'd0, k};
   assign sum = written_ff + {29'd0, k};
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      written_in = written_ff;
      finished_in = finished_ff;
      left_in = left_ff;
      pix_in = pix_ff;
      drop_in = drop_ff;
      fmt_in = fmt_ff;
      pop = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pix_in = rsp_pix_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;
      rsp_ovf_in = rsp_ovf_ff;
      rsp_fmt_in = rsp_fmt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop = 1'b1;
               pix_in = job.pixel;
               fmt_in = job.fmt_err;
               left_in = job.fmt_err ? 8'd0 : valid_n;
               drop_in = !job.fmt_err && (valid_n < job.count);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in = pix_ff;
               rsp_cnt_in = k;
               rsp_last_in = left_next == 8'd0;
               rsp_done_in = !fmt_ff && k != 3'd0 && left_next == 8'd0 && sum == total_ff;
               rsp_ovf_in = drop_ff;
               rsp_fmt_in = fmt_ff;
               written_in = sum;
               left_in = left_next;
               if (rsp_done_in) begin
                  finished_in = 1'b1;
               end
               if (left_next == 8'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel_a = (rsp_cnt_ff >= 3'd1) ? rsp_pix_ff : 24'd0;
   assign rsp_chan.pixel_b = (rsp_cnt_ff >= 3'd2) ? rsp_pix_ff : 24'd0;
   assign rsp_chan.pixel_c = (rsp_cnt_ff >= 3'd3) ? rsp_pix_ff : 24'd0;
   assign rsp_chan.pixel_d = (rsp_cnt_ff >= 3'd4) ? rsp_pix_ff : 24'd0;
   assign rsp_chan.pixels_valid = rsp_cnt_ff;
   assign rsp_chan.run_last = rsp_last_ff;
   assign rsp_chan.image_done = rsp_done_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;
   assign rsp_chan.format_error = rsp_fmt_ff;

   always_ff @(posedge clock) begin
      total_ff <= total_prod;
      pix_ff <= pix_in;
      drop_ff <= drop_in;
      fmt_ff <= fmt_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_fmt_ff <= rsp_fmt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         written_ff <= 32'd0;
         finished_ff <= 1'b0;
         left_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         written_ff <= written_in;
         finished_ff <= finished_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
